@@ rtl/ohash_pkg.sv @@
package ohash_pkg;

	localparam int Capacity   = 256;
	localparam int SlotBits   = 8;
	localparam int KeyWidth   = 32;
	localparam int ValueWidth = 32;
	localparam int CountBits  = 9;

	localparam logic [CountBits-1:0] FillLimitReset = 9'd192;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_LIVE  = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		OP_PUT = 2'd0,
		OP_GET = 2'd1,
		OP_DEL = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		RES_INSERTED = 3'd0,
		RES_UPDATED  = 3'd1,
		RES_FOUND    = 3'd2,
		RES_NOTFOUND = 3'd3,
		RES_DELETED  = 3'd4,
		RES_FULL     = 3'd5
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_WRITE,
		ST_DONE
	} fsm_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [KeyWidth-1:0]   key;
		logic [ValueWidth-1:0] value;
	} request_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [ValueWidth-1:0] value_out;
		logic [SlotBits-1:0]   slot_index;
		logic [CountBits-1:0]  live_count;
	} response_t;

	// One slot entry as stored: state, key and value in a single word
	localparam int EntryWidth = 2 + KeyWidth + ValueWidth;

endpackage

@@ rtl/ohash_ram.sv @@
module ohash_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/open_addressing_hash_table_unit.sv @@
// Channel  | Ports                     | Handshake
// request  | start, busy, req          | taken when start && !busy
// response | done, resp                | one cycle strobe on done
// config   | cfg_valid, cfg_ready, cfg | written when cfg_valid && cfg_ready
//
// Each probe step is a slot read, then a compare, one step per slot
// visited. A write-back state follows every put, get and delete, used or not,
// then a result state; the unused op code skips the write-back. A request
// settled at its home slot holds busy through read, compare, write-back and
// result; the next word can be taken in the cycle after done. After reset a
// clearing pass marks all 256 slots empty, busy held high. The receiver cannot stall.
module open_addressing_hash_table_unit
	import ohash_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  request_t             req,
	output logic                 done,
	output response_t            resp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CountBits-1:0] cfg
);

	fsm_t state_q, state_d;
	request_t req_q;
	logic [SlotBits-1:0] idx_q, tomb_at_q, where_q;
	logic [CountBits-1:0] steps_q, live_q, tomb_q, limit_q;
	logic tomb_seen_q;
	response_t resp_q;

	logic we;
	logic [SlotBits-1:0] waddr, raddr;
	logic [EntryWidth-1:0] wdata, rdata;

	ohash_ram #(.Width(EntryWidth), .Depth(Capacity)) u_slots (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [1:0]            r_state;
	logic [KeyWidth-1:0]   r_key;
	logic [ValueWidth-1:0] r_val;
	assign r_state = rdata[EntryWidth-1 -: 2];
	assign r_key   = rdata[ValueWidth +: KeyWidth];
	assign r_val   = rdata[ValueWidth-1:0];

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = (state_q == ST_DONE);
	assign resp      = resp_q;
	assign raddr     = idx_q;

	// Decision made when a probe step ends
	logic hit, stop, has_slot, can_ins;
	logic [SlotBits-1:0] put_at;
	logic [CountBits:0] used;
	always_comb begin
		hit      = (r_state == SLOT_LIVE) && (r_key == req_q.key);
		stop     = hit || (r_state == SLOT_EMPTY) || (steps_q == CountBits'(Capacity - 1));
		has_slot = tomb_seen_q || (r_state == SLOT_EMPTY) || (r_state == SLOT_TOMB);
		if (tomb_seen_q) begin
			put_at = tomb_at_q;
		end else begin
			put_at = idx_q;
		end
		used    = {1'b0, live_q} + {1'b0, tomb_q} + 10'd1;
		can_ins = (used <= {1'b0, limit_q}) && has_slot;
	end

	// Live count after the committed change
	logic [CountBits-1:0] live_d;
	always_comb begin
		live_d = live_q;
		if (state_q == ST_WRITE) begin
			if (resp_q.status == RES_INSERTED) begin
				live_d = live_q + 1'b1;
			end else if (resp_q.status == RES_DELETED) begin
				live_d = live_q - 1'b1;
			end
		end
	end

	// Next state and memory write
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = where_q;
		wdata   = {SLOT_LIVE, req_q.key, req_q.value};
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = '0;
				if (idx_q == SlotBits'(Capacity - 1)) state_d = ST_IDLE;
			end
			ST_IDLE:  if (start) state_d = ST_READ;
			ST_READ:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (req_q.op == OP_NOP) state_d = ST_DONE;
				else if (stop) state_d = ST_WRITE;
				else state_d = ST_READ;
			end
			ST_WRITE: begin
				state_d = ST_DONE;
				if (resp_q.status == RES_INSERTED || resp_q.status == RES_UPDATED) begin
					we = 1'b1;
				end else if (resp_q.status == RES_DELETED) begin
					we    = 1'b1;
					wdata = {SLOT_TOMB, req_q.key, req_q.value};
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			live_q  <= '0;
			tomb_q  <= '0;
			limit_q <= FillLimitReset;
		end else begin
			state_q <= state_d;
			live_q  <= live_d;
			if (cfg_valid) limit_q <= cfg;
			case (state_q)
				ST_CLEAR: idx_q <= idx_q + 1'b1;
				ST_IDLE:  idx_q <= req.key[SlotBits-1:0];
				ST_CHECK: if (!stop) idx_q <= idx_q + 1'b1;
				ST_WRITE: begin
					// Update the tombstone count for the committed change
					if (resp_q.status == RES_INSERTED) begin
						if (tomb_seen_q) tomb_q <= tomb_q - 1'b1;
					end else if (resp_q.status == RES_DELETED) begin
						tomb_q <= tomb_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Request word, probe tracking and result word
	always_ff @(posedge clk) begin
		resp_q.live_count <= live_d;
		case (state_q)
			ST_IDLE: begin
				req_q       <= req;
				steps_q     <= '0;
				tomb_seen_q <= 1'b0;
				resp_q.status     <= RES_NOTFOUND;
				resp_q.value_out  <= '0;
				resp_q.slot_index <= '0;
			end
			ST_CHECK: begin
				steps_q <= steps_q + 1'b1;
				if (r_state == SLOT_TOMB && !tomb_seen_q) begin
					tomb_seen_q <= 1'b1;
					tomb_at_q   <= idx_q;
				end
				if (stop) begin
					case (req_q.op)
						OP_PUT: begin
							if (hit) begin
								resp_q.status     <= RES_UPDATED;
								resp_q.slot_index <= idx_q;
								where_q           <= idx_q;
							end else if (can_ins) begin
								resp_q.status     <= RES_INSERTED;
								resp_q.slot_index <= put_at;
								where_q           <= put_at;
							end else begin
								resp_q.status <= RES_FULL;
							end
						end
						OP_GET: if (hit) begin
							resp_q.status     <= RES_FOUND;
							resp_q.value_out  <= r_val;
							resp_q.slot_index <= idx_q;
						end
						OP_DEL: if (hit) begin
							resp_q.status     <= RES_DELETED;
							resp_q.slot_index <= idx_q;
							where_q           <= idx_q;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

@@ test/ohash_checker.sv @@
module ohash_checker
	import ohash_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  request_t             req,
	input  logic                 done,
	input  response_t            resp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CountBits-1:0] cfg,
	output int                   pending,
	output int                   errors
);

	slot_state_t           slot_state [Capacity];
	logic [KeyWidth-1:0]   slot_key   [Capacity];
	logic [ValueWidth-1:0] slot_val   [Capacity];
	logic [CountBits-1:0]  live_cnt;
	logic [CountBits-1:0]  tomb_cnt;
	logic [CountBits-1:0]  fill_limit;
	response_t             expected_words [$];

	// Walk the table for one request and update the table copy
	function automatic response_t apply_request(request_t r);
		response_t             res;
		logic [SlotBits-1:0]   idx;
		logic [SlotBits-1:0]   tomb_at;
		logic [SlotBits-1:0]   target;
		bit                    tomb_seen;
		bit                    hit;
		bit                    has_slot;
		bit                    stopped;
		res = '0;
		res.status = RES_NOTFOUND;
		idx = r.key[SlotBits-1:0];
		tomb_seen = 0;
		tomb_at = '0;
		hit = 0;
		has_slot = 0;
		stopped = 0;
		target = '0;
		if (op_t'(r.op) != OP_NOP) begin
			for (int n = 0; n < Capacity && !stopped; n++) begin
				if (slot_state[idx] == SLOT_EMPTY) begin
					target = tomb_seen ? tomb_at : idx;
					has_slot = 1;
					stopped = 1;
				end else if (slot_state[idx] == SLOT_TOMB) begin
					if (!tomb_seen) begin
						tomb_seen = 1;
						tomb_at = idx;
					end
				end else if (slot_key[idx] == r.key) begin
					target = idx;
					hit = 1;
					has_slot = 1;
					stopped = 1;
				end
				if (!stopped)
					idx = idx + 1'b1;
			end
			if (!stopped) begin
				target = tomb_at;
				has_slot = tomb_seen;
			end
			case (op_t'(r.op))
				OP_PUT: begin
					if (hit) begin
						slot_val[target] = r.value;
						res.status = RES_UPDATED;
						res.slot_index = target;
					end else if ({1'b0, live_cnt} + tomb_cnt + 1 > fill_limit || !has_slot) begin
						res.status = RES_FULL;
					end else begin
						if (slot_state[target] == SLOT_TOMB)
							tomb_cnt = tomb_cnt - 1'b1;
						live_cnt = live_cnt + 1'b1;
						slot_state[target] = SLOT_LIVE;
						slot_key[target] = r.key;
						slot_val[target] = r.value;
						res.status = RES_INSERTED;
						res.slot_index = target;
					end
				end
				OP_GET: begin
					if (hit) begin
						res.status = RES_FOUND;
						res.value_out = slot_val[target];
						res.slot_index = target;
					end
				end
				default: begin
					if (hit) begin
						slot_state[target] = SLOT_TOMB;
						live_cnt = live_cnt - 1'b1;
						tomb_cnt = tomb_cnt + 1'b1;
						res.status = RES_DELETED;
						res.slot_index = target;
					end
				end
			endcase
		end
		res.live_count = live_cnt;
		return res;
	endfunction

	assign pending = expected_words.size();

	// Track config, predict on accepted words, compare each result word
	always @(posedge clk or negedge arst_n) begin
		response_t exp_word;
		if (!arst_n) begin
			for (int i = 0; i < Capacity; i++)
				slot_state[i] = SLOT_EMPTY;
			live_cnt = '0;
			tomb_cnt = '0;
			fill_limit = FillLimitReset;
			expected_words.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				fill_limit = cfg;
			if (start && !busy)
				expected_words.push_back(apply_request(req));
			if (done) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word: %p", resp);
				end else begin
					exp_word = expected_words.pop_front();
					if (resp.status !== exp_word.status ||
					    resp.value_out !== exp_word.value_out ||
					    resp.slot_index !== exp_word.slot_index ||
					    resp.live_count !== exp_word.live_count) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %p, got %p", exp_word, resp);
					end
				end
			end
		end
	end

endmodule

@@ test/tb.sv @@
module tb;
	import ohash_pkg::*;

	localparam int CycleLimit = 5000000;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 start = 0;
	logic                 busy;
	request_t             req = '0;
	logic                 done;
	response_t            resp;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CountBits-1:0] cfg = '0;
	int                   pending;
	int                   errors;
	int                   cycles = 0;
	int                   item_count = 0;
	logic [KeyWidth-1:0]  key_pool [48];

	open_addressing_hash_table_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .resp(resp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg)
	);

	ohash_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .resp(resp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg),
		.pending(pending), .errors(errors)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[open_addressing_hash_table_unit] ERROR");
			$finish;
		end
	end

	// Send one request word, with an occasional gap before it
	task automatic send(op_t op, logic [KeyWidth-1:0] key, logic [ValueWidth-1:0] value);
		int gap;
		gap = 0;
		if ((item_count < 700 || item_count >= 1000) && $urandom_range(0, 99) < 16)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		req <= '{op: op, key: key, value: value};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		item_count++;
	endtask

	// Wait for all outstanding results, then write the fill limit
	task automatic set_limit(logic [CountBits-1:0] limit);
		start <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1;
		cfg <= limit;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	// Clustered keys: few home slots, random upper bits
	task automatic refill_pool();
		logic [SlotBits-1:0] home;
		for (int i = 0; i < 48; i++) begin
			home = SlotBits'($urandom_range(0, 11) * 21);
			key_pool[i] = {24'($urandom()), home};
		end
	endtask

	function automatic logic [KeyWidth-1:0] pick_key();
		if ($urandom_range(0, 99) < 75)
			return key_pool[$urandom_range(0, 47)];
		return $urandom();
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return OP_PUT;
		if (r < 72)
			return OP_GET;
		if (r < 95)
			return OP_DEL;
		return OP_NOP;
	endfunction

	initial begin
		logic [CountBits-1:0] limits [7];
		limits = '{9'd8, 9'd1, 9'd40, 9'd256, 9'd511, 9'd100, 9'd192};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		set_limit(9'd192);

		// Directed: empty table, extremes, collisions, wrap, tombstones
		send(OP_GET, 32'd7, 32'd0);
		send(OP_DEL, 32'd7, 32'd0);
		send(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_PUT, 32'd0, 32'd0);
		send(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
		send(OP_GET, 32'hFFFF_FFFF, 32'd0);
		send(OP_PUT, 32'd511, 32'hA5A5_A5A5);
		send(OP_GET, 32'd511, 32'd0);
		send(OP_PUT, 32'd5, 32'd1);
		send(OP_PUT, 32'd261, 32'd2);
		send(OP_PUT, 32'd517, 32'd3);
		send(OP_DEL, 32'd261, 32'd0);
		send(OP_GET, 32'd517, 32'd0);
		send(OP_GET, 32'd261, 32'd0);
		send(OP_PUT, 32'd1029, 32'd4);
		send(OP_DEL, 32'd0, 32'd0);
		send(OP_GET, 32'd0, 32'd0);
		set_limit(9'd0);
		send(OP_PUT, 32'd77, 32'd9);
		send(OP_PUT, 32'd5, 32'hFFFF_0000);
		send(OP_GET, 32'd5, 32'd0);
		set_limit(9'd256);

		// Fill every slot so new keys run a full lap
		for (int i = 0; i < 300; i++)
			send(OP_PUT, {24'($urandom()), i[7:0]}, $urandom());
		for (int i = 0; i < 40; i++)
			send(OP_DEL, {22'd0, 2'($urandom_range(0, 3)), i[7:0]}, 32'd0);

		// Random phases across fill limits
		foreach (limits[p]) begin
			set_limit(limits[p]);
			refill_pool();
			for (int i = 0; i < 185; i++)
				send(pick_op(), pick_key(), $urandom());
		end

		start <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[open_addressing_hash_table_unit] OK");
		else
			$display("[open_addressing_hash_table_unit] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ohash_pkg.sv
rtl/ohash_ram.sv
rtl/open_addressing_hash_table_unit.sv
test/ohash_checker.sv
test/tb.sv
